// ===== hw/rtl/lfu_cache_table_defines.svh =====
// Assertion macros for the LFU cache table.
// No dependencies; included by the top level only.
`ifndef LFU_CACHE_TABLE_DEFINES_SVH
`define LFU_CACHE_TABLE_DEFINES_SVH

// Check that cons holds at the same edge as ante.
`define LFU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds at the edge after ante.
`define LFU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/lfu_pkg.sv =====
// Shared constants for the LFU cache table.
// No dependencies.
package lfu_pkg;
	localparam int unsigned KEY_W = 32;
	localparam int unsigned CAP_W = 5;
	localparam int unsigned APB_AW = 3;
	localparam logic MODE_GET = 1'b0;
	localparam logic MODE_PUT = 1'b1;
	localparam logic REG_CAPACITY = 1'b0;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
	localparam logic [KEY_W-1:0] MISS_VALUE = '1;
endpackage

// ===== hw/rtl/lfu_mem.sv =====
// Entry memory of the LFU cache table: one write and one read port,
// read data registered. Depends on lfu_pkg.
module lfu_mem #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW = 4,
	parameter int unsigned DW = 84
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	import lfu_pkg::*;

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== hw/rtl/lfu_cache_table.sv =====
// LFU cache table, one request at a time. Each request walks the entry memory
// twice, one entry per cycle: a match pass that finds the key, the lowest free
// slot and the eviction victim (lowest use count, oldest among equals), then
// an update pass that writes the touched entry and ages the recency ranks of
// younger entries. A get miss skips the update pass, and a request with
// capacity zero skips both passes. The result sits in an output register,
// so a new request is taken while it waits. Depends on lfu_pkg, lfu_mem and
// lfu_cache_table_defines.svh.
`include "lfu_cache_table_defines.svh"

module lfu_cache_table #(
	parameter int unsigned ENTRIES = 16,
	parameter int unsigned COUNT_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        mode,
	input  logic [lfu_pkg::KEY_W-1:0]   lookup_key,
	input  logic [lfu_pkg::KEY_W-1:0]   write_value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        hit,
	output logic [lfu_pkg::KEY_W-1:0]   read_value,
	output logic                        evicted,
	output logic [lfu_pkg::KEY_W-1:0]   evicted_key,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lfu_pkg::APB_AW-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import lfu_pkg::*;

	localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned RW = IW;
	localparam int unsigned FW = $clog2(ENTRIES + 1);
	localparam int unsigned CMPW = (FW > CAP_W) ? FW : CAP_W;
	localparam int unsigned CB = COUNT_BITS;
	localparam int unsigned EW = 2 * KEY_W + CB + RW;

	typedef enum logic [2:0] {ST_IDLE, ST_SCAN, ST_DECIDE, ST_UPD, ST_DONE} state_t;

	state_t state_q;

	// configuration
	logic [CAP_W-1:0] cap_q;
	logic             cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
	assign prdata = (paddr[2] == REG_CAPACITY) ? 32'(cap_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_wr) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	logic [CMPW-1:0] cap_ext, cap_eff;
	assign cap_ext = CMPW'(cap_q);
	assign cap_eff = (cap_ext > CMPW'(ENTRIES)) ? CMPW'(ENTRIES) : cap_ext;

	// entry memory: {key, value, count, rank}
	logic          mem_we;
	logic [IW-1:0] mem_waddr;
	logic [EW-1:0] mem_wdata, mem_rdata;
	logic [IW:0]   rd_cnt_q;

	lfu_mem #(.DEPTH(ENTRIES), .AW(IW), .DW(EW)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (rd_cnt_q[IW-1:0]),
		.rdata (mem_rdata)
	);

	logic [KEY_W-1:0] rd_key, rd_val;
	logic [CB-1:0]    rd_cnt;
	logic [RW-1:0]    rd_rank;
	assign rd_key  = mem_rdata[EW-1 -: KEY_W];
	assign rd_val  = mem_rdata[CB+RW +: KEY_W];
	assign rd_cnt  = mem_rdata[RW +: CB];
	assign rd_rank = mem_rdata[RW-1:0];

	// request and pass state
	logic             req_put_q;
	logic [KEY_W-1:0] req_key_q, req_val_q;
	logic             v_s1;
	logic [IW-1:0]    idx_s1;
	logic [ENTRIES-1:0] valid_q;
	logic [FW-1:0]    fill_q;

	logic             mt_found_q;
	logic [IW-1:0]    mt_slot_q;
	logic [KEY_W-1:0] mt_val_q;
	logic [CB-1:0]    mt_cnt_q;
	logic [RW-1:0]    mt_rank_q;
	logic             fr_have_q;
	logic [IW-1:0]    fr_slot_q;
	logic             vc_have_q;
	logic [IW-1:0]    vc_slot_q;
	logic [KEY_W-1:0] vc_key_q;
	logic [CB-1:0]    vc_cnt_q;
	logic [RW-1:0]    vc_rank_q;
	logic [IW-1:0]    tg_slot_q;
	logic [RW-1:0]    tg_lim_q;
	logic             tg_all_q;
	logic [CB-1:0]    tg_cnt_q;
	logic [KEY_W-1:0] tg_val_q;

	logic             res_hit_q, res_ev_q;
	logic [KEY_W-1:0] res_val_q, res_key_q;
	logic             out_valid_q;

	logic last_s1, upd_age;
	assign last_s1 = v_s1 && (idx_s1 == IW'(ENTRIES - 1));
	assign upd_age = valid_q[idx_s1] && (tg_all_q || (rd_rank < tg_lim_q));

	// update pass write-back: rewrite the target, age younger entries
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_s1;
		mem_wdata = mem_rdata;
		if (state_q == ST_UPD && v_s1) begin
			if (idx_s1 == tg_slot_q) begin
				mem_we    = 1'b1;
				mem_wdata = {req_key_q, tg_val_q, tg_cnt_q, RW'(0)};
			end else if (upd_age) begin
				mem_we    = 1'b1;
				mem_wdata = {rd_key, rd_val, rd_cnt, rd_rank + RW'(1)};
			end
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			fill_q      <= '0;
			rd_cnt_q    <= '0;
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
			mt_found_q  <= 1'b0;
			fr_have_q   <= 1'b0;
			vc_have_q   <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						req_put_q  <= mode;
						req_key_q  <= lookup_key;
						req_val_q  <= write_value;
						res_hit_q  <= 1'b0;
						res_ev_q   <= 1'b0;
						res_key_q  <= '0;
						res_val_q  <= (mode == MODE_PUT) ? '0 : MISS_VALUE;
						mt_found_q <= 1'b0;
						fr_have_q  <= 1'b0;
						vc_have_q  <= 1'b0;
						rd_cnt_q   <= '0;
						// capacity zero: answer at once, touch nothing
						state_q    <= (cap_q == '0) ? ST_DONE : ST_SCAN;
					end
				end
				ST_SCAN, ST_UPD: begin
					if (rd_cnt_q < (IW+1)'(ENTRIES)) begin
						v_s1     <= 1'b1;
						idx_s1   <= rd_cnt_q[IW-1:0];
						rd_cnt_q <= rd_cnt_q + (IW+1)'(1);
					end else begin
						v_s1 <= 1'b0;
					end
					if (state_q == ST_SCAN && v_s1) begin
						if (valid_q[idx_s1]) begin
							if (!mt_found_q && rd_key == req_key_q) begin
								mt_found_q <= 1'b1;
								mt_slot_q  <= idx_s1;
								mt_val_q   <= rd_val;
								mt_cnt_q   <= rd_cnt;
								mt_rank_q  <= rd_rank;
							end
							if (!vc_have_q || rd_cnt < vc_cnt_q ||
							    (rd_cnt == vc_cnt_q && rd_rank > vc_rank_q)) begin
								vc_have_q <= 1'b1;
								vc_slot_q <= idx_s1;
								vc_key_q  <= rd_key;
								vc_cnt_q  <= rd_cnt;
								vc_rank_q <= rd_rank;
							end
						end else if (!fr_have_q) begin
							fr_have_q <= 1'b1;
							fr_slot_q <= idx_s1;
						end
					end
					if (last_s1) begin
						v_s1     <= 1'b0;
						rd_cnt_q <= '0;
						state_q  <= (state_q == ST_SCAN) ? ST_DECIDE : ST_DONE;
					end
				end
				ST_DECIDE: begin
					tg_all_q <= 1'b0;
					tg_cnt_q <= CB'(1);
					tg_val_q <= req_val_q;
					state_q  <= ST_UPD;
					if (mt_found_q) begin
						tg_slot_q <= mt_slot_q;
						tg_lim_q  <= mt_rank_q;
						tg_cnt_q  <= (&mt_cnt_q) ? mt_cnt_q : mt_cnt_q + CB'(1);
						res_hit_q <= 1'b1;
						if (req_put_q == MODE_GET) begin
							tg_val_q  <= mt_val_q;
							res_val_q <= mt_val_q;
						end
					end else if (req_put_q == MODE_GET) begin
						state_q <= ST_DONE;
					end else if (CMPW'(fill_q) < cap_eff) begin
						// insert into the lowest free slot; every other valid entry ages
						tg_slot_q          <= fr_slot_q;
						tg_lim_q           <= '0;
						tg_all_q           <= 1'b1;
						valid_q[fr_slot_q] <= 1'b1;
						fill_q             <= fill_q + FW'(1);
					end else begin
						tg_slot_q <= vc_slot_q;
						tg_lim_q  <= vc_rank_q;
						res_ev_q  <= 1'b1;
						res_key_q <= vc_key_q;
					end
				end
				ST_DONE: begin
					// hand over once the output register is free
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						hit         <= res_hit_q;
						read_value  <= res_val_q;
						evicted     <= res_ev_q;
						evicted_key <= res_key_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;

	`LFU_ASSERT_NOW(a_fill_match, 1'b1, $countones(valid_q) == 32'(fill_q), "fill count off")
	`LFU_ASSERT_NOW(a_wr_in_upd, mem_we, state_q == ST_UPD, "memory write outside update")
	`LFU_ASSERT_NEXT(a_fill_bound, state_q == ST_DECIDE, fill_q <= FW'(ENTRIES), "fill too high")
endmodule

// ===== verif/lfu_cache_table_checker.sv =====
// Result checker for the LFU cache table: predicts every reply and compares it.
// Depends on lfu_pkg; instantiated beside the block by lfu_cache_table_test.
module lfu_cache_table_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  logic                       mode,
	input  logic [lfu_pkg::KEY_W-1:0]  lookup_key,
	input  logic [lfu_pkg::KEY_W-1:0]  write_value,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  logic                       hit,
	input  logic [lfu_pkg::KEY_W-1:0]  read_value,
	input  logic                       evicted,
	input  logic [lfu_pkg::KEY_W-1:0]  evicted_key,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [lfu_pkg::APB_AW-1:0] paddr,
	input  logic [31:0]                pwdata,
	input  logic                       pready,
	output int                         pending,
	output int                         mismatches
);
	import lfu_pkg::*;

	localparam int SLOTS = 16;
	localparam logic [15:0] USE_MAX = 16'hFFFF;

	typedef struct packed {
		logic              hit;
		logic [KEY_W-1:0]  read_value;
		logic              evicted;
		logic [KEY_W-1:0]  evicted_key;
	} reply_t;

	logic [CAP_W-1:0] capacity = CAP_RESET;
	bit               slot_valid [SLOTS];
	logic [KEY_W-1:0] slot_key [SLOTS];
	logic [KEY_W-1:0] slot_value [SLOTS];
	logic [15:0]      slot_uses [SLOTS];
	int               slot_age [SLOTS];
	int               fill = 0;
	reply_t           expected_replies [$];

	initial begin
		pending = 0;
		mismatches = 0;
		foreach (slot_valid[i]) slot_valid[i] = 0;
	end

	// Make slot s the most recent; valid entries younger than limit age by one.
	function automatic void make_newest(input int s, input int limit);
		for (int i = 0; i < SLOTS; i++)
			if (slot_valid[i] && i != s && slot_age[i] < limit)
				slot_age[i]++;
		slot_age[s] = 0;
	endfunction

	function automatic reply_t serve_request(input logic put, input logic [KEY_W-1:0] key,
			input logic [KEY_W-1:0] val);
		reply_t r;
		int     cap;
		int     slot;
		bit     found;
		r = '0;
		slot = 0;
		found = 0;
		cap = (capacity > SLOTS) ? SLOTS : capacity;
		if (cap == 0) begin
			if (put == MODE_GET) r.read_value = MISS_VALUE;
			return r;
		end
		for (int i = 0; i < SLOTS; i++)
			if (slot_valid[i] && slot_key[i] == key && !found) begin
				found = 1;
				slot = i;
			end
		if (found) begin
			r.hit = 1'b1;
			if (slot_uses[slot] < USE_MAX) slot_uses[slot]++;
			make_newest(slot, slot_age[slot]);
			if (put == MODE_PUT) slot_value[slot] = val;
			else r.read_value = slot_value[slot];
			return r;
		end
		if (put == MODE_GET) begin
			r.read_value = MISS_VALUE;
			return r;
		end
		if (fill < cap) begin
			for (int i = SLOTS - 1; i >= 0; i--)
				if (!slot_valid[i]) slot = i;
			fill++;
			slot_valid[slot] = 1'b1;
			slot_key[slot] = key;
			slot_value[slot] = val;
			slot_uses[slot] = 16'd1;
			make_newest(slot, SLOTS + 1);
		end else begin
			found = 0;
			// victim: fewest uses, oldest among equals
			for (int i = 0; i < SLOTS; i++) begin
				if (!slot_valid[i]) continue;
				if (!found || slot_uses[i] < slot_uses[slot] ||
						(slot_uses[i] == slot_uses[slot] && slot_age[i] > slot_age[slot])) begin
					found = 1;
					slot = i;
				end
			end
			r.evicted = 1'b1;
			r.evicted_key = slot_key[slot];
			slot_key[slot] = key;
			slot_value[slot] = val;
			slot_uses[slot] = 16'd1;
			make_newest(slot, slot_age[slot]);
		end
		return r;
	endfunction

	task automatic report(input string what, input logic [KEY_W-1:0] got,
			input logic [KEY_W-1:0] want);
		$display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		reply_t want;
		reply_t fresh;
		if (arst_n) begin
			if (psel && penable && pwrite && pready && paddr[2] == REG_CAPACITY)
				capacity = pwdata[CAP_W-1:0];
			if (in_valid && in_ready) begin
				fresh = serve_request(mode, lookup_key, write_value);
				expected_replies = {expected_replies, fresh};
			end
			if (out_valid && out_ready) begin
				if (expected_replies.size() == 0) begin
					report("unexpected reply, key", evicted_key, '0);
				end else begin
					want = expected_replies.pop_front();
					if (hit !== want.hit) report("hit", KEY_W'(hit), KEY_W'(want.hit));
					if (read_value !== want.read_value)
						report("read_value", read_value, want.read_value);
					if (evicted !== want.evicted)
						report("evicted", KEY_W'(evicted), KEY_W'(want.evicted));
					if (evicted_key !== want.evicted_key)
						report("evicted_key", evicted_key, want.evicted_key);
				end
			end
			pending = expected_replies.size();
		end
	end
endmodule

// ===== verif/lfu_cache_table_test.sv =====
// Testbench top for the LFU cache table: clock, reset, requests, config writes.
// Depends on lfu_pkg, lfu_cache_table and lfu_cache_table_checker.
module lfu_cache_table_test;
	import lfu_pkg::*;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic              mode = MODE_GET;
	logic [KEY_W-1:0]  lookup_key = '0;
	logic [KEY_W-1:0]  write_value = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              hit;
	logic [KEY_W-1:0]  read_value;
	logic              evicted;
	logic [KEY_W-1:0]  evicted_key;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;
	int                pending;
	int                mismatches;

	// idle odds in percent for the request side and the reply side
	int                send_idle = 0;
	int                take_stall = 0;
	logic [KEY_W-1:0]  key_pool [20];

	lfu_cache_table i_dut (.*);

	lfu_cache_table_checker i_checker (.*);

	initial begin
		forever #10 clk = ~clk;
	end

	// Hard stop: far beyond the slowest legal run.
	initial begin
		#10_000_000;
		$display("FAIL lfu_cache_table");
		$finish;
	end

	// Stall the reply side at random; odds follow the current phase.
	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= take_stall);

	// Send one request; hold valid and payload until the transfer happens.
	task automatic send(input logic put, input logic [KEY_W-1:0] key,
			input logic [KEY_W-1:0] val);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= put;
		lookup_key <= key;
		write_value <= val;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Drain outstanding replies, then write the capacity register (setup, access).
	task automatic set_capacity(input logic [CAP_W-1:0] cap);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= APB_AW'(REG_CAPACITY * 4);
		pwdata <= {$urandom} & ~32'h1F | cap;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly reuse a small key pool so hits and evictions are common.
	function automatic logic [KEY_W-1:0] pick_key();
		int r;
		r = $urandom_range(99);
		if (r < 75) return key_pool[$urandom_range(19)];
		if (r < 85) begin
			case ($urandom_range(3))
				0: return 32'h8000_0000;
				1: return 32'h7FFF_FFFF;
				2: return 32'h0;
				default: return 32'hFFFF_FFFF;
			endcase
		end
		return $urandom;
	endfunction

	initial begin
		logic [CAP_W-1:0] caps [8];
		caps = '{5'd31, 5'd1, 5'd3, 5'd16, 5'd0, 5'd5, 5'd2, 5'd16};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extreme keys and values at reset capacity.
		send(MODE_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
		send(MODE_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
		send(MODE_PUT, 32'h0, 32'h0);
		send(MODE_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send(MODE_GET, 32'h8000_0000, 32'h1234_5678);
		send(MODE_GET, 32'h7FFF_FFFF, 32'h0);
		send(MODE_GET, 32'hFFFF_FFFF, 32'h0);
		send(MODE_GET, 32'h0000_3039, 32'h0);
		send(MODE_PUT, 32'h0, 32'h5);
		send(MODE_GET, 32'h0, 32'h0);
		// Lower capacity below the fill: puts now evict least used, oldest first.
		set_capacity(5'd2);
		send(MODE_PUT, 32'h11, 32'h11);
		send(MODE_GET, 32'h11, 32'h0);
		send(MODE_PUT, 32'h22, 32'h22);
		send(MODE_PUT, 32'h33, 32'h33);
		// Capacity zero: gets miss on stored keys, puts are dropped.
		set_capacity(5'd0);
		send(MODE_GET, 32'h0, 32'h0);
		send(MODE_PUT, 32'h44, 32'h44);
		send(MODE_GET, 32'h44, 32'h0);
		// Capacity above the table size saturates.
		set_capacity(5'd31);
		for (int i = 0; i < 18; i++) send(MODE_PUT, 32'h100 + i, i);

		// Random phases: each new capacity and idle pattern, fresh key pool.
		for (int p = 0; p < 8; p++) begin
			set_capacity(caps[p]);
			case (p % 4)
				0: begin send_idle = 0;  take_stall = 0;  end
				1: begin send_idle = 58; take_stall = 0;  end
				2: begin send_idle = 0;  take_stall = 58; end
				default: begin send_idle = 14; take_stall = 14; end
			endcase
			foreach (key_pool[i]) key_pool[i] = $urandom;
			for (int n = 0; n < 115; n++)
				send($urandom_range(1) ? MODE_PUT : MODE_GET, pick_key(), $urandom);
		end

		in_valid <= 1'b0;
		send_idle = 0;
		take_stall = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (mismatches == 0)
			$display("PASS lfu_cache_table");
		else
			$display("FAIL lfu_cache_table");
		$finish;
	end
endmodule

// ===== lfu_cache_table.f =====
+incdir+hw/rtl
hw/rtl/lfu_pkg.sv
hw/rtl/lfu_mem.sv
hw/rtl/lfu_cache_table.sv
verif/lfu_cache_table_checker.sv
verif/lfu_cache_table_test.sv
